### src/fisr_pkg.sv
`timescale 1ns / 1ps
package fisr_pkg;
	localparam logic [31:0] SEED_CONST = 32'h5F3759DF;
	localparam logic [31:0] F32_HALF = 32'h3F000000;
	localparam logic [31:0] F32_THREE_HALVES = 32'h3FC00000;
	localparam logic [31:0] F32_QNAN = 32'h7FC00000;
	localparam logic [31:0] F32_SIGN = 32'h80000000;

	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        zero;
		logic        sign;
		logic signed [10:0] e;
		logic [23:0] m;
	} unp_t;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	function automatic logic [5:0] lzc64(input logic [63:0] v);
		logic [5:0] n;
		n = 6'd63;
		for (int i = 0; i < 63; i++) begin
			if (v[i]) n = 6'(62 - i);
		end
		return n;
	endfunction

	function automatic unp_t unpack(input logic [31:0] a);
		unp_t u;
		logic [4:0] z;
		u.sign = a[31];
		u.nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		u.inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		u.zero = (a[30:0] == 31'd0);
		if (a[30:23] == 8'd0) begin
			z = lzc24({1'b0, a[22:0]});
			u.m = {1'b0, a[22:0]} << z;
			u.e = 11'sd1 - 11'(z);
		end else begin
			u.m = {1'b1, a[22:0]};
			u.e = 11'(a[30:23]);
		end
		return u;
	endfunction

	function automatic logic [63:0] shr_sticky(input logic [63:0] v, input logic signed [11:0] s);
		logic [63:0] r;
		logic [63:0] msk;
		if (s <= 0) begin
			r = v;
		end else if (s >= 63) begin
			r = {63'd0, v != 64'd0};
		end else begin
			msk = (64'd1 << s[5:0]) - 64'd1;
			r = (v >> s[5:0]) | {63'd0, (v & msk) != 64'd0};
		end
		return r;
	endfunction

	// sig has bit 62 set; value = sig/2^62 * 2^(e-127)
	function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] ei,
			input logic [63:0] sigi);
		logic [63:0] sig;
		logic signed [11:0] e;
		logic [38:0] low;
		logic [24:0] m;
		sig = sigi;
		e = ei;
		if (e < 1) begin
			sig = shr_sticky(sig, 12'sd1 - e);
			e = 12'sd1;
		end
		low = sig[38:0];
		m = {1'b0, sig[62:39]};
		if (low > 39'h4000000000 || (low == 39'h4000000000 && m[0])) m = m + 25'd1;
		if (m[24]) begin
			m = m >> 1;
			e = e + 12'sd1;
		end
		if (e >= 255) return {sign, 8'hFF, 23'd0};
		return {sign, (m[23] ? e[7:0] : 8'd0), m[22:0]};
	endfunction
endpackage

### src/fast_inverse_square_root.sv
`timescale 1ns / 1ps
// Pipeline: four multiplies and one subtract, two register stages each; the last
// multiply stage is the output register.
// Throughput: one beat per cycle; the pipeline advances whenever the output
// register is empty or taken.
// Reset clears all valid bits and the special-case flags in each unit; other data registers are not reset.
module fast_inverse_square_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // operand_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // result_bits
);
	localparam int DEPTH = 10;
	logic [DEPTH-1:0] vld_q;
	logic en;
	logic [31:0] h, y_in, t1, t2, u, r;
	logic [31:0] y_q [0:7];

	assign en = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];
	assign y_in = fisr_pkg::SEED_CONST - {s_tdata[31], s_tdata[31:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_q[0] <= y_in;
			for (int i = 1; i < 8; i++) y_q[i] <= y_q[i-1];
		end
	end

	fisr_mul u_half (.clk, .arst_n, .en, .a(fisr_pkg::F32_HALF), .b(s_tdata), .p(h));
	fisr_mul u_hy (.clk, .arst_n, .en, .a(h), .b(y_q[1]), .p(t1));
	fisr_mul u_ty (.clk, .arst_n, .en, .a(t1), .b(y_q[3]), .p(t2));
	fisr_sub u_sub (.clk, .arst_n, .en, .t(t2), .d(u));
	fisr_mul u_out (.clk, .arst_n, .en, .a(y_q[7]), .b(u), .p(r));

	assign m_tdata = r;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted beat lost");
endmodule

### src/fisr_mul.sv
`timescale 1ns / 1ps
module fisr_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	fisr_pkg::unp_t ua, ub;
	logic [47:0] prod_s1;
	logic signed [11:0] e_s1;
	logic sign_s1, spec_s1;
	logic [31:0] spec_val_s1;
	logic [31:0] spec_val;
	logic spec;
	logic [63:0] sig;
	logic signed [11:0] e;

	assign ua = fisr_pkg::unpack(a);
	assign ub = fisr_pkg::unpack(b);

	always_comb begin
		spec = 1'b1;
		if (ua.nan || ub.nan) spec_val = fisr_pkg::F32_QNAN;
		else if (ua.inf) spec_val = ub.zero ? fisr_pkg::F32_QNAN : {ua.sign ^ ub.sign, 8'hFF, 23'd0};
		else if (ub.inf) spec_val = ua.zero ? fisr_pkg::F32_QNAN : {ua.sign ^ ub.sign, 8'hFF, 23'd0};
		else if (ua.zero || ub.zero) spec_val = {ua.sign ^ ub.sign, 31'd0};
		else begin
			spec = 1'b0;
			spec_val = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_s1 <= 1'b0;
		end else if (en) begin
			spec_s1 <= spec;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ua.m * ub.m;
			e_s1 <= 12'(ua.e) + 12'(ub.e) - 12'sd126;
			sign_s1 <= ua.sign ^ ub.sign;
			spec_val_s1 <= spec_val;
		end
	end

	always_comb begin
		sig = {1'b0, prod_s1, 15'd0};
		e = e_s1;
		if (!sig[62]) begin
			sig = sig << 1;
			e = e - 12'sd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) p <= spec_s1 ? spec_val_s1 : fisr_pkg::round_pack(sign_s1, e, sig);
	end
endmodule

### src/fisr_sub.sv
`timescale 1ns / 1ps
// computes 1.5 - t
module fisr_sub (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [31:0] t,
	output logic [31:0] d
);
	logic [31:0] a, b;
	fisr_pkg::unp_t ua, ub;
	logic spec;
	logic [31:0] spec_val;
	logic [63:0] sa, sb;
	logic signed [10:0] ea, eb;
	logic sga, sgb;
	logic spec_s1, sga_s1, zero_s1;
	logic [31:0] spec_val_s1;
	logic [63:0] sig_s1;
	logic signed [11:0] e_s1;
	logic [63:0] sig;
	logic [5:0] z;

	assign a = fisr_pkg::F32_THREE_HALVES;
	assign b = t ^ fisr_pkg::F32_SIGN;
	assign ua = fisr_pkg::unpack(a);
	assign ub = fisr_pkg::unpack(b);

	always_comb begin
		spec = 1'b1;
		if (ub.nan) spec_val = fisr_pkg::F32_QNAN;
		else if (ub.inf) spec_val = b;
		else if (ub.zero) spec_val = a;
		else begin
			spec = 1'b0;
			spec_val = 32'd0;
		end
		if (ua.e < ub.e || (ua.e == ub.e && ua.m < ub.m)) begin
			ea = ub.e; sa = {ub.m, 40'd0} >> 2; sga = ub.sign;
			eb = ua.e; sb = {ua.m, 40'd0} >> 2; sgb = ua.sign;
		end else begin
			ea = ua.e; sa = {ua.m, 40'd0} >> 2; sga = ua.sign;
			eb = ub.e; sb = {ub.m, 40'd0} >> 2; sgb = ub.sign;
		end
		sb = fisr_pkg::shr_sticky(sb, 12'(ea) - 12'(eb));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_s1 <= 1'b0;
		end else if (en) begin
			spec_s1 <= spec;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sig_s1 <= (sga == sgb) ? sa + sb : sa - sb;
			e_s1 <= 12'(ea) + 12'sd1;
			sga_s1 <= sga;
			spec_val_s1 <= spec_val;
		end
	end

	assign zero_s1 = (sig_s1 == 64'd0);
	assign z = fisr_pkg::lzc64(sig_s1);
	assign sig = sig_s1 << z;

	always_ff @(posedge clk) begin
		if (en) begin
			if (spec_s1) d <= spec_val_s1;
			else if (zero_s1) d <= 32'd0;
			else d <= fisr_pkg::round_pack(sga_s1, e_s1 - 12'(z), sig);
		end
	end
endmodule
